>>> design/sha512_block_compress_core_defines.svh
// ----------------------------------------------------------------------------
// SHA-512 block compression core: assertion macros
// Shared concurrent assertion wrappers for the checker of this block.
// ----------------------------------------------------------------------------
`ifndef SHA512_BLOCK_COMPRESS_CORE_DEFINES_SVH
`define SHA512_BLOCK_COMPRESS_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is high
`define SBC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define SBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sbc_pkg.sv
// ----------------------------------------------------------------------------
// SHA-512 block compression package
// Widths, round constants, initial chaining values, queue entry and state
// types, and the SHA-512 sigma functions.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int WORD_W      = 64;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUND_COUNT = 80;
  localparam int CHAIN_WORDS = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int CNT_W   = $clog2(BLOCK_WORDS);
  localparam int ROUND_W = $clog2(ROUND_COUNT);
  localparam int IDX_W   = $clog2(CHAIN_WORDS);

  typedef logic [WORD_W-1:0] word_t;

  // One request as it travels from the front end to the compression engine
  typedef struct packed {
    word_t word;
    logic  start;   // reload initial chaining values before this word
    logic  close;   // sixteenth word of its block
  } entry_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PREP,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam word_t INITIAL_CHAIN [CHAIN_WORDS] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  localparam word_t ROUND_K [ROUND_COUNT] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  // Round constant lookup; indexes past the last round read as zero
  function automatic word_t round_k(input logic [ROUND_W-1:0] idx);
    word_t k;
    k = '0;
    if (idx < ROUND_W'(ROUND_COUNT)) begin
      k = ROUND_K[idx];
    end
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

>>> design/sbc_msg_if.sv
// ----------------------------------------------------------------------------
// Message word channel
// Valid/ready channel carrying one padded message word and its start flag.
// ----------------------------------------------------------------------------
interface sbc_msg_if;
  logic                valid;
  logic                ready;
  logic [63:0]         message_word;
  logic                start_new;

  modport source (output valid, output message_word, output start_new, input ready);
  modport sink   (input valid, input message_word, input start_new, output ready);
endinterface

>>> design/sbc_dig_if.sv
// ----------------------------------------------------------------------------
// Digest word channel
// Valid/ready channel carrying one updated chaining word with its index.
// ----------------------------------------------------------------------------
interface sbc_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

>>> design/sbc_front.sv
// ----------------------------------------------------------------------------
// SHA-512 compression front end
// Accepts message words, tracks the position within the block and tags each
// request with its start and block-closing marks for the queue.
// ----------------------------------------------------------------------------
module sbc_front (
  input  logic            clk,
  input  logic            rst,
  sbc_msg_if.sink         message,
  output logic            push_valid,
  input  logic            push_ready,
  output sbc_pkg::entry_t push_entry
);
  import sbc_pkg::*;

  logic [CNT_W-1:0] word_count;
  logic [CNT_W-1:0] word_count_next;
  logic [CNT_W-1:0] position;
  logic             accept;

  assign message.ready = push_ready;
  assign push_valid    = message.valid;
  assign accept        = message.valid && push_ready;

  // A start flag drops any partial block: this word becomes word 0
  assign position        = message.start_new ? '0 : word_count;
  assign word_count_next = position + CNT_W'(1);

  always_comb begin
    push_entry.word  = message.message_word;
    push_entry.start = message.start_new;
    push_entry.close = (position == CNT_W'(BLOCK_WORDS - 1));
  end

  // Advance the block position on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (accept) begin
      word_count <= word_count_next;
    end
  end

endmodule

>>> design/sbc_queue.sv
// ----------------------------------------------------------------------------
// SHA-512 compression request queue
// Small FIFO between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sbc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  sbc_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop_ready,
  output sbc_pkg::entry_t pop_entry
);
  import sbc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  entry_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != FILL_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> design/sbc_back.sv
// ----------------------------------------------------------------------------
// SHA-512 compression engine
// Collects sixteen words into the schedule window, runs the 80 rounds one per
// cycle, folds the result into the chaining words and sends them out.
// ----------------------------------------------------------------------------
module sbc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  sbc_pkg::entry_t pop_entry,
  sbc_dig_if.source       digest
);
  import sbc_pkg::*;

  state_t             state;
  state_t             state_next;
  word_t              chain [CHAIN_WORDS];
  word_t              v [CHAIN_WORDS];
  word_t              win [BLOCK_WORDS];
  word_t              hkw;
  logic [ROUND_W-1:0] round;
  logic [IDX_W-1:0]   emit_idx;
  logic               out_valid;
  word_t              out_word;
  logic [IDX_W-1:0]   out_index;
  logic               out_last;

  logic  do_pop;
  logic  emit_fire;
  logic  last_round;
  logic  last_emit;
  word_t ch;
  word_t maj;
  word_t t1;
  word_t t2;
  word_t w_new;

  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.word_index  = out_index;
  assign digest.last_word   = out_last;

  assign last_round = (round == ROUND_W'(ROUND_COUNT - 1));
  assign last_emit  = (emit_idx == IDX_W'(CHAIN_WORDS - 1));
  assign do_pop     = pop_valid && pop_ready;

  // Round function and schedule extension
  always_comb begin
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = hkw + big_sigma1(v[4]) + ch;
    t2    = big_sigma0(v[0]) + maj;
    w_new = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: if (do_pop && pop_entry.close) state_next = ST_PREP;
      ST_PREP:    state_next = ST_ROUND;
      ST_ROUND:   if (last_round) state_next = ST_FOLD;
      ST_FOLD:    state_next = ST_EMIT;
      ST_EMIT:    if (emit_fire && last_emit) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_ready = 1'b0;
    emit_fire = 1'b0;
    case (state)
      ST_COLLECT: pop_ready = 1'b1;
      ST_EMIT:    emit_fire = !out_valid || digest.ready;
      default: begin
        pop_ready = 1'b0;
        emit_fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // Chaining words: reload on start, fold in the round result at block end
  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= INITIAL_CHAIN;
    end else if (do_pop && pop_entry.start) begin
      chain <= INITIAL_CHAIN;
    end else if (state == ST_FOLD) begin
      for (int i = 0; i < CHAIN_WORDS; i++) begin
        chain[i] <= chain[i] + v[i];
      end
    end
  end

  // Schedule window: shift in message words, then extended words per round
  always_ff @(posedge clk) begin
    if (do_pop || state == ST_ROUND) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[BLOCK_WORDS - 1] <= do_pop ? pop_entry.word : w_new;
    end
  end

  // Working variables, round counter and the h + K + W lookahead
  always_ff @(posedge clk) begin
    case (state)
      ST_PREP: begin
        v     <= chain;
        hkw   <= chain[7] + round_k('0) + win[0];
        round <= '0;
      end
      ST_ROUND: begin
        // Shift a..h down one place, with new a and e from the round
        v[7]  <= v[6];
        v[6]  <= v[5];
        v[5]  <= v[4];
        v[4]  <= v[3] + t1;
        v[3]  <= v[2];
        v[2]  <= v[1];
        v[1]  <= v[0];
        v[0]  <= t1 + t2;
        hkw   <= v[6] + round_k(round + ROUND_W'(1)) + win[1];
        round <= round + ROUND_W'(1);
      end
      default: begin
        round <= round;
      end
    endcase
  end

  // Step through the chaining words while sending
  always_ff @(posedge clk) begin
    if (state == ST_FOLD) begin
      emit_idx <= '0;
    end else if (emit_fire) begin
      emit_idx <= emit_idx + IDX_W'(1);
    end
  end

  // Output register: load the next word, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (digest.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_word  <= chain[emit_idx];
      out_index <= emit_idx;
      out_last  <= last_emit;
    end
  end

endmodule

>>> design/sha512_block_compress_core.sv
// ----------------------------------------------------------------------------
// SHA-512 block compression core
// Compresses padded 1024-bit blocks into the running SHA-512 chaining value.
// ----------------------------------------------------------------------------
// Usage:
//   message: one 64-bit big-endian word per request, sixteen per block. Set
//     start_new on a message's first word to reload the initial chaining
//     values; a partial block collected so far is then dropped.
//   digest: after each sixteenth word, eight requests carry the updated
//     chaining words a..h (word_index 0..7), last_word set on h.
// Path: the sixteenth word passes the queue, a set-up state, the 80 rounds at
//   one per cycle on the single round unit, a fold state and the output
//   register before the first digest word appears.
// Flow: a block costs 16 word loads, the compression and 8 sends, and the
//   engine takes no new word while it compresses or sends; the front end
//   takes one word per cycle while its four-entry queue has room.
// Reset: clears the queue and word position and loads the initial chaining
//   values. A stalled digest receiver holds the engine in its send phase;
//   words keep being taken until the queue fills.
// ----------------------------------------------------------------------------
module sha512_block_compress_core (
  input logic     clk,
  input logic     rst,
  sbc_msg_if.sink message,
  sbc_dig_if.source digest
);
  import sbc_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  sbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .message    (message),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  sbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  sbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .digest    (digest)
  );

endmodule

>>> design/sbc_checker.sv
// ----------------------------------------------------------------------------
// SHA-512 block compression checker
// Port-level assertions on the digest channel, bound to the core.
// ----------------------------------------------------------------------------
`include "sha512_block_compress_core_defines.svh"

module sbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        dvalid,
  input logic        dready,
  input logic [63:0] dword,
  input logic [2:0]  dindex,
  input logic        dlast
);
  import sbc_pkg::*;

  // Hold a stalled digest request
  `SBC_ASSERT(a_stall_hold, clk, rst, dvalid && !dready |=> dvalid && $stable(dword) && $stable(dindex), "digest request changed while stalled")

  // Mark only word h as last
  `SBC_ASSERT(a_last_on_h, clk, rst, dvalid |-> (dlast == (dindex == IDX_W'(CHAIN_WORDS - 1))), "last_word does not match word h")

  // Open every burst of digest words with word a
  `SBC_ASSERT(a_burst_starts_a, clk, rst, $rose(dvalid) |-> (dindex == '0), "digest burst does not start at word a")

  // Drop digest valid after reset
  `SBC_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !dvalid, "digest valid after reset")

endmodule

bind sha512_block_compress_core sbc_checker u_sbc_checker (
  .clk    (clk),
  .rst    (rst),
  .dvalid (digest.valid),
  .dready (digest.ready),
  .dword  (digest.digest_word),
  .dindex (digest.word_index),
  .dlast  (digest.last_word)
);

>>> tb/sha512_block_compress_checker.sv
// ----------------------------------------------------------------------------
// SHA-512 block compression checker
// Watches the message and digest channels, keeps its own copy of the chaining
// words and block buffer, predicts the eight digest words of every completed
// block and compares each accepted digest request with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sha512_block_compress_checker (
  input  logic clk,
  input  logic rst,
  sbc_msg_if   msg,
  sbc_dig_if   dig,
  output int   fail_count,
  output int   pending
);
  import sbc_pkg::*;

  // One predicted digest request
  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_t;

  word_t      chain_now [CHAIN_WORDS];
  word_t      block_buf [BLOCK_WORDS];
  logic [3:0] fill;
  digest_t    digests_due [$];
  digest_t    due;

  // Print one line and count it
  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t checker: %s", $time, what);
  endtask

  function automatic word_t ror64(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  // Round mixing of word a
  function automatic word_t rot_sum_a(input word_t x);
    return ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
  endfunction

  // Round mixing of word e
  function automatic word_t rot_sum_e(input word_t x);
    return ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
  endfunction

  // Schedule mixing of the word fifteen back
  function automatic word_t sched_mix_lo(input word_t x);
    return ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
  endfunction

  // Schedule mixing of the word two back
  function automatic word_t sched_mix_hi(input word_t x);
    return ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
  endfunction

  // Run the 80 rounds on the full buffer and add into the chaining words
  function automatic void fold_block();
    word_t sched [ROUND_COUNT];
    word_t v [CHAIN_WORDS];
    word_t t1;
    word_t t2;
    word_t choose;
    word_t major;
    for (int t = 0; t < BLOCK_WORDS; t++) sched[t] = block_buf[t];
    for (int t = BLOCK_WORDS; t < ROUND_COUNT; t++) begin
      sched[t] = sched_mix_hi(sched[t-2]) + sched[t-7] + sched_mix_lo(sched[t-15])
                 + sched[t-16];
    end
    for (int i = 0; i < CHAIN_WORDS; i++) v[i] = chain_now[i];
    for (int t = 0; t < ROUND_COUNT; t++) begin
      choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
      major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1     = v[7] + rot_sum_e(v[4]) + choose + ROUND_K[t] + sched[t];
      t2     = rot_sum_a(v[0]) + major;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < CHAIN_WORDS; i++) chain_now[i] = chain_now[i] + v[i];
  endfunction

  // Take one message word; queue eight digest words when a block closes
  function automatic void absorb_word(input word_t w, input logic restart);
    digest_t d;
    if (restart) begin
      for (int i = 0; i < CHAIN_WORDS; i++) chain_now[i] = INITIAL_CHAIN[i];
      fill = '0;
    end
    block_buf[fill] = w;
    fill = fill + 4'd1;
    if (fill == '0) begin
      fold_block();
      for (int i = 0; i < CHAIN_WORDS; i++) begin
        d.word  = chain_now[i];
        d.index = 3'(i);
        d.last  = (i == CHAIN_WORDS - 1);
        digests_due.push_back(d);
      end
    end
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Predict on accepted message words, compare accepted digest words
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHAIN_WORDS; i++) chain_now[i] = INITIAL_CHAIN[i];
      fill = '0;
      digests_due.delete();
    end else begin
      if (msg.valid && msg.ready) begin
        absorb_word(msg.message_word, msg.start_new);
      end
      if (dig.valid && dig.ready) begin
        if (digests_due.size() == 0) begin
          report_mismatch($sformatf("digest word %h index %0d with nothing due",
                                    dig.digest_word, dig.word_index));
        end else begin
          due = digests_due.pop_front();
          if (dig.digest_word !== due.word) begin
            report_mismatch($sformatf("digest_word %h, wanted %h (index %0d)",
                                      dig.digest_word, due.word, due.index));
          end
          if (dig.word_index !== due.index) begin
            report_mismatch($sformatf("word_index %0d, wanted %0d",
                                      dig.word_index, due.index));
          end
          if (dig.last_word !== due.last) begin
            report_mismatch($sformatf("last_word %b, wanted %b (index %0d)",
                                      dig.last_word, due.last, due.index));
          end
        end
      end
    end
    pending = digests_due.size();
  end

endmodule

>>> tb/tb_sha512_block_compress_core.sv
// ----------------------------------------------------------------------------
// SHA-512 block compression core testbench
// Feeds padded message words (directed blocks, then random messages with some
// broken and noisy ones) with random gaps and digest back-pressure; the
// checker beside the block predicts and compares every digest word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sha512_block_compress_core;
  import sbc_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   words_sent;
  int   digests_taken;
  bit   held_off;
  int   stall_left;

  sbc_msg_if msg_ch ();
  sbc_dig_if dig_ch ();

  sha512_block_compress_core DUT (
    .clk     (clk),
    .rst     (rst),
    .message (msg_ch),
    .digest  (dig_ch)
  );

  sha512_block_compress_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg_ch),
    .dig        (dig_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock, period 4 ns
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Random payload with the extremes mixed in
  function automatic word_t pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Offer one request after a gap; return at the falling edge after acceptance
  task automatic send_word(input word_t w, input logic restart, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : idle_len();
    if (gap > 0) begin
      msg_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_ch.valid        = 1'b1;
    msg_ch.message_word = w;
    msg_ch.start_new    = restart;
    do @(posedge clk); while (!msg_ch.ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Count digest requests taken
  always @(posedge clk) begin
    if (rst) begin
      digests_taken <= 0;
    end else if (dig_ch.valid && dig_ch.ready) begin
      digests_taken <= digests_taken + 1;
    end
  end

  // Digest receiver: random stalls, one long hold-off mid-run
  initial begin
    dig_ch.ready = 1'b0;
    held_off     = 1'b0;
    stall_left   = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_off && digests_taken >= 17) begin
        held_off     = 1'b1;
        dig_ch.ready = 1'b0;
        repeat (600) @(negedge clk);
      end
      if (stall_left > 0) begin
        dig_ch.ready = 1'b0;
        stall_left--;
      end else begin
        dig_ch.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
      @(negedge clk);
    end
  end

  // Hard limit on the run
  initial begin
    #2_000_000;
    $display("[sha512_block_compress_core] ERROR");
    $finish;
  end

  // Reset, stimulus and verdict
  initial begin
    int    kind;
    int    count;
    bit    burst;
    rst                 = 1'b1;
    words_sent          = 0;
    msg_ch.valid        = 1'b0;
    msg_ch.message_word = '0;
    msg_ch.start_new    = 1'b0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Block straight after reset without a start flag, extreme words
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      send_word((i % 2 == 0) ? '1 : '0, 1'b0, 1'b0);
    end
    // Partial block, then a start flag mid-block to drop it
    for (int i = 0; i < 4; i++) send_word(pick_word(), 1'b0, 1'b0);
    send_word(64'h8000_0000_0000_0001, 1'b1, 1'b0);

    // Hold the sender until every digest word has come
    msg_ch.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);

    // Random messages, mostly well formed
    while (words_sent < 85) begin
      kind  = $urandom_range(0, 9);
      burst = ($urandom_range(0, 3) == 0);
      if (kind < 7) begin
        // whole message of one to three blocks
        count = BLOCK_WORDS * $urandom_range(1, 3);
        for (int i = 0; i < count; i++) send_word(pick_word(), i == 0, burst);
      end else if (kind == 7) begin
        // message cut short; the next start flag lands mid-block
        count = $urandom_range(2, 15);
        for (int i = 0; i < count; i++) send_word(pick_word(), i == 0, burst);
      end else if (kind == 8) begin
        // noise with random start flags
        count = $urandom_range(1, 20);
        for (int i = 0; i < count; i++) begin
          send_word(pick_word(), $urandom_range(0, 3) == 0, burst);
        end
      end else begin
        // carry on from the current chaining words
        for (int i = 0; i < BLOCK_WORDS; i++) send_word(pick_word(), 1'b0, burst);
      end
    end
    msg_ch.valid = 1'b0;

    // Drain, then allow the engine latency for anything stray
    wait (pending == 0);
    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sha512_block_compress_core] OK");
    end else begin
      $display("[sha512_block_compress_core] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/sbc_pkg.sv
design/sbc_msg_if.sv
design/sbc_dig_if.sv
design/sbc_front.sv
design/sbc_queue.sv
design/sbc_back.sv
design/sha512_block_compress_core.sv
design/sbc_checker.sv
tb/sha512_block_compress_checker.sv
tb/tb_sha512_block_compress_core.sv
